FILE: rtl/hdlc_byte_stuffing_codec_assert.svh
// Assertion macros shared by the codec modules
`ifndef HDLC_BYTE_STUFFING_CODEC_ASSERT_SVH
`define HDLC_BYTE_STUFFING_CODEC_ASSERT_SVH

// same-cycle implication, checked outside reset
`define HBS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hbs assertion failed");

// next-cycle implication, checked outside reset
`define HBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hbs assertion failed");

`endif

FILE: rtl/hbs_pkg.sv
// Types and constants of the HDLC byte stuffing codec
package hbs_pkg;

   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] ESC_XOR   = 8'h20;

   // one queued job: the beats that a single input item produces
   typedef struct packed {
      logic       open_flag;   // leading 0x7E
      logic       escape;      // 0x7D before the data byte
      logic [7:0] data;        // data byte, already XORed when escaped
      logic       close_flag;  // trailing 0x7E, carries frame_end
      logic       data_end;    // data byte carries frame_end (decode)
   } job_type;

endpackage

FILE: rtl/hbs_front.sv
// Front end: accepts input beats, tracks decode state, builds jobs
`include "hdlc_byte_stuffing_codec_assert.svh"

module hbs_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [7:0]      req_data_byte,
   input  logic            req_first_of_frame,
   input  logic            req_last_of_frame,
   input  logic            csr_write,
   input  logic            csr_encode_mode,
   input  logic            q_full,
   output logic            q_push,
   output hbs_pkg::job_type q_job
);
   import hbs_pkg::*;

   logic       encode_mode_ff;
   logic       escape_pending_ff, escape_pending_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic       held_valid_ff, held_valid_in;

   logic       accept;
   logic       push_job;
   logic       is_special;
   logic       have;
   logic [7:0] dec_byte;

   assign req_ready  = !q_full;
   assign accept     = req_valid && req_ready;
   assign is_special = (req_data_byte == FLAG_BYTE) || (req_data_byte == ESC_BYTE);
   assign q_push     = accept && push_job;

   always_comb begin
      escape_pending_in = escape_pending_ff;
      held_byte_in      = held_byte_ff;
      held_valid_in     = held_valid_ff;
      push_job          = 1'b0;
      q_job             = '0;
      have              = 1'b0;
      dec_byte          = req_data_byte;
      if (encode_mode_ff) begin
         q_job.open_flag  = req_first_of_frame;
         q_job.escape     = is_special;
         q_job.data       = is_special ? (req_data_byte ^ ESC_XOR) : req_data_byte;
         q_job.close_flag = req_last_of_frame;
         push_job         = 1'b1;
      end else if (req_first_of_frame) begin
         escape_pending_in = 1'b0;
         held_byte_in      = '0;
         held_valid_in     = 1'b0;
      end else if (req_last_of_frame) begin
         // flush the held byte as the frame's last data byte
         q_job.data        = held_byte_ff;
         q_job.data_end    = 1'b1;
         push_job          = held_valid_ff;
         escape_pending_in = 1'b0;
         held_byte_in      = '0;
         held_valid_in     = 1'b0;
      end else begin
         if (escape_pending_ff) begin
            have              = 1'b1;
            dec_byte          = req_data_byte ^ ESC_XOR;
            escape_pending_in = 1'b0;
         end else if (req_data_byte == ESC_BYTE) begin
            escape_pending_in = 1'b1;
         end else begin
            have = 1'b1;
         end
         if (have) begin
            q_job.data    = held_byte_ff;
            push_job      = held_valid_ff;
            held_byte_in  = dec_byte;
            held_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         encode_mode_ff    <= 1'b1;
         escape_pending_ff <= 1'b0;
         held_byte_ff      <= '0;
         held_valid_ff     <= 1'b0;
      end else begin
         if (csr_write) begin
            encode_mode_ff <= csr_encode_mode;
         end
         if (accept) begin
            escape_pending_ff <= escape_pending_in;
            held_byte_ff      <= held_byte_in;
            held_valid_ff     <= held_valid_in;
         end
      end
   end

   `HBS_ASSERT_NEXT(a_dec_frame_edge_clears, clock, reset, accept && !encode_mode_ff && (req_first_of_frame || req_last_of_frame), !held_valid_ff && !escape_pending_ff)
   `HBS_ASSERT_NOW(a_no_push_when_full, clock, reset, q_full, !q_push)

endmodule

FILE: rtl/hbs_queue.sv
// Job queue between front end and back end
`include "hdlc_byte_stuffing_codec_assert.svh"

module hbs_queue #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hbs_pkg::job_type push_job,
   output logic             full,
   input  logic             pop,
   output hbs_pkg::job_type head,
   output logic             empty
);
   import hbs_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `HBS_ASSERT_NOW(a_count_in_range, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `HBS_ASSERT_NOW(a_no_pop_when_empty, clock, reset, empty, !pop)

endmodule

FILE: rtl/hbs_back.sv
// Back end: walks each job beat by beat into the output register
`include "hdlc_byte_stuffing_codec_assert.svh"

module hbs_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  hbs_pkg::job_type q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_run_end,
   output logic             rsp_frame_end
);
   import hbs_pkg::*;

   localparam logic [1:0] STEP_OPEN  = 2'd0;
   localparam logic [1:0] STEP_ESC   = 2'd1;
   localparam logic [1:0] STEP_DATA  = 2'd2;
   localparam logic [1:0] STEP_CLOSE = 2'd3;

   logic       busy_ff, busy_in;
   logic [1:0] step_ff, step_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       run_end_ff, run_end_in;
   logic       frame_end_ff, frame_end_in;

   logic [1:0] step;
   logic [1:0] next_step;
   logic       last_beat;
   logic       emit;

   assign emit = !q_empty && (!valid_ff || rsp_ready);

   always_comb begin
      if (busy_ff) begin
         step = step_ff;
      end else if (q_head.open_flag) begin
         step = STEP_OPEN;
      end else if (q_head.escape) begin
         step = STEP_ESC;
      end else begin
         step = STEP_DATA;
      end
   end

   always_comb begin
      next_step    = STEP_DATA;
      last_beat    = 1'b0;
      byte_in      = q_head.data;
      frame_end_in = 1'b0;
      unique case (step)
         STEP_OPEN: begin
            next_step = q_head.escape ? STEP_ESC : STEP_DATA;
            byte_in   = FLAG_BYTE;
         end
         STEP_ESC: begin
            next_step = STEP_DATA;
            byte_in   = ESC_BYTE;
         end
         STEP_DATA: begin
            next_step    = STEP_CLOSE;
            last_beat    = !q_head.close_flag;
            frame_end_in = q_head.data_end;
         end
         STEP_CLOSE: begin
            last_beat    = 1'b1;
            byte_in      = FLAG_BYTE;
            frame_end_in = 1'b1;
         end
         default: begin
            last_beat = 1'b1;
         end
      endcase
      run_end_in = last_beat;
   end

   assign q_pop = emit && last_beat;

   always_comb begin
      busy_in  = busy_ff;
      step_in  = step_ff;
      valid_in = valid_ff;
      if (emit) begin
         busy_in  = !last_beat;
         step_in  = next_step;
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         step_ff  <= STEP_OPEN;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         byte_ff      <= byte_in;
         run_end_ff   <= run_end_in;
         frame_end_ff <= frame_end_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_out_byte  = byte_ff;
   assign rsp_run_end   = run_end_ff;
   assign rsp_frame_end = frame_end_ff;

   `HBS_ASSERT_NOW(a_busy_has_job, clock, reset, busy_ff, !q_empty)
   `HBS_ASSERT_NEXT(a_mid_job_stays_busy, clock, reset, emit && !last_beat, busy_ff)

endmodule

FILE: rtl/hdlc_byte_stuffing_codec.sv
// Top level of the HDLC byte stuffing codec
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    data_byte, first_of_frame, last_of_frame
//   rsp      out        rsp_valid/rsp_ready    out_byte, run_end, frame_end
//   csr      in         csr_write              encode_mode
//
// The front end takes one input beat per cycle while the job queue has room.
// The back end sends one output beat per cycle while the output is not stalled;
// an item goes out as its beats in order: opening flag, escape, data byte, closing flag.
// Decoded items that hold back or drop their byte make no output beat.
// Reset clears the queue, the decode state and the output valid flag; encode is on.
// Either side may stall; the job queue absorbs up to QUEUE_DEPTH pending items.

module hdlc_byte_stuffing_codec #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_of_frame,
   input  logic       req_last_of_frame,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_end,
   output logic       rsp_frame_end,
   input  logic       csr_write,
   input  logic       csr_encode_mode
);
   import hbs_pkg::*;

   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;
   job_type push_job;
   job_type head_job;

   hbs_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_first_of_frame (req_first_of_frame),
      .req_last_of_frame  (req_last_of_frame),
      .csr_write          (csr_write),
      .csr_encode_mode    (csr_encode_mode),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_job              (push_job)
   );

   hbs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .head     (head_job),
      .empty    (q_empty)
   );

   hbs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_empty       (q_empty),
      .q_head        (head_job),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_run_end   (rsp_run_end),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule
